>>> design/hsv_to_rgb_converter_assert.svh
// Assertion macros for the HSV to RGB converter.
// Used by hsv_to_rgb_converter.sv; needs nothing else.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTR_ASSERT_NOW(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTR_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/htr_pkg.sv
// Package for the HSV to RGB converter: fixed-point constants and sector codes.
// No dependencies.
package htr_pkg;

  // degrees per radian, 16 fraction bits
  localparam logic [21:0] DEG_PER_RAD = 22'd3754938;

  // hue in degrees, 8 fraction bits
  localparam logic [16:0] HUE_FULL = 17'd92160;
  localparam logic [13:0] HUE_SECT = 14'd15360;
  localparam logic [16:0] HUE_B1   = 17'd15360;
  localparam logic [16:0] HUE_B2   = 17'd30720;
  localparam logic [16:0] HUE_B3   = 17'd46080;
  localparam logic [16:0] HUE_B4   = 17'd61440;
  localparam logic [16:0] HUE_B5   = 17'd76800;

  // floor(2^32 / HUE_FULL)
  localparam logic [15:0] WRAP_RECIP = 16'((64'd1 << 32) / 64'd92160);

  // channel = round(num / (255 * sector))
  localparam logic [29:0] CH_DEN   = 30'd3916800;
  localparam logic [29:0] CH_HALF  = 30'd1958400;
  localparam logic [30:0] CH_RECIP = 31'((64'd1 << 52) / 64'd3916800);

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

>>> design/hsv_to_rgb_converter.sv
// HSV to RGB converter, ten-stage pipeline.
// Depends on htr_pkg and hsv_to_rgb_converter_assert.svh.
//
// Usage:
//   Input channel in_*: one pixel per transfer, hue in signed radians
//   (HUE_FRAC_BITS fraction bits), saturation and brightness 0..255.
//   Output channel out_*: red, green, blue, 0..255, rounded to nearest.
//   out_tvalid rises when the pixel reaches the last stage register; the result
//   can transfer at the next edge. Throughput: one pixel per cycle with out_tready high.
//   Each stage holds one pixel with its own valid bit; a stage loads when
//   it is empty or when the stage after it moves on, so bubbles collapse.
//   Stages: input capture, radians-to-degrees multiply, rounding, wrap
//   quotient estimate, remainder, wrap and sign fix, sector decode,
//   channel numerators, reciprocal multiply, quotient correction/output.
//   When out_tready is low the result stays on out_tdata and the pipe
//   keeps accepting until all ten stages hold a pixel; only then does
//   in_tready drop. Nothing is dropped or repeated across a stall.
//   Reset (rst_n low, synchronous) clears all valid bits; data registers
//   are not reset.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] hue_radians, [23:16] saturation, [31:24] brightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
  import htr_pkg::*;

  localparam int NSTG  = 10;
  localparam int SH    = HUE_FRAC_BITS + 8;
  localparam int DEG_W = 39 - SH;
  localparam int QP_W  = DEG_W + 16;
  localparam int Q_W   = QP_W - 32;

  logic [NSTG-1:0] vld_r, vld_nxt, load;

  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld_r[k] || load[k+1];
    end
    for (int k = 0; k < NSTG; k++) begin
      if (load[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = load[0];

  // stage 1: capture, magnitude
  logic        p1_neg_r, p1_neg_nxt;
  logic [16:0] p1_mag_r, p1_mag_nxt;
  logic [7:0]  p1_sat_r, p1_bri_r;

  always_comb begin
    p1_neg_nxt = in_tdata[15];
    p1_mag_nxt = p1_neg_nxt ? (17'h10000 - {1'b0, in_tdata[15:0]}) : {1'b0, in_tdata[15:0]};
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      p1_neg_r <= p1_neg_nxt;
      p1_mag_r <= p1_mag_nxt;
      p1_sat_r <= in_tdata[23:16];
      p1_bri_r <= in_tdata[31:24];
    end
  end

  // stage 2: radians to degrees
  logic [36:0] p2_prod_r, p2_prod_nxt;
  logic        p2_neg_r;
  logic [7:0]  p2_sat_r, p2_bri_r;

  assign p2_prod_nxt = 37'(p1_mag_r) * 37'(DEG_PER_RAD);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      p2_prod_r <= p2_prod_nxt;
      p2_neg_r  <= p1_neg_r;
      p2_sat_r  <= p1_sat_r;
      p2_bri_r  <= p1_bri_r;
    end
  end

  // stage 3: round half up on magnitude
  logic [37:0]      p3_sum;
  logic [DEG_W-1:0] p3_deg_r, p3_deg_nxt;
  logic             p3_neg_r;
  logic [7:0]       p3_sat_r, p3_bri_r;

  always_comb begin
    p3_sum     = {1'b0, p2_prod_r} + (38'd1 << (SH - 1));
    p3_deg_nxt = DEG_W'(p3_sum >> SH);
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      p3_deg_r <= p3_deg_nxt;
      p3_neg_r <= p2_neg_r;
      p3_sat_r <= p2_sat_r;
      p3_bri_r <= p2_bri_r;
    end
  end

  // stage 4: quotient estimate of degrees / 360
  logic [QP_W-1:0]  p4_qprod;
  logic [Q_W-1:0]   p4_q_r, p4_q_nxt;
  logic [DEG_W-1:0] p4_deg_r;
  logic             p4_neg_r;
  logic [7:0]       p4_sat_r, p4_bri_r;

  always_comb begin
    p4_qprod = QP_W'(p3_deg_r) * QP_W'(WRAP_RECIP);
    p4_q_nxt = p4_qprod[QP_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      p4_q_r   <= p4_q_nxt;
      p4_deg_r <= p3_deg_r;
      p4_neg_r <= p3_neg_r;
      p4_sat_r <= p3_sat_r;
      p4_bri_r <= p3_bri_r;
    end
  end

  // stage 5: remainder, below twice the full circle
  logic [DEG_W-1:0] p5_rfull;
  logic [17:0]      p5_r0_r, p5_r0_nxt;
  logic             p5_neg_r;
  logic [7:0]       p5_sat_r, p5_bri_r;

  always_comb begin
    p5_rfull  = p4_deg_r - DEG_W'(p4_q_r) * DEG_W'(HUE_FULL);
    p5_r0_nxt = p5_rfull[17:0];
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      p5_r0_r  <= p5_r0_nxt;
      p5_neg_r <= p4_neg_r;
      p5_sat_r <= p4_sat_r;
      p5_bri_r <= p4_bri_r;
    end
  end

  // stage 6: final wrap and sign
  logic [16:0] p6_rem;
  logic [16:0] p6_h_r, p6_h_nxt;
  logic [7:0]  p6_sat_r, p6_bri_r;

  always_comb begin
    if (p5_r0_r >= 18'(HUE_FULL)) begin
      p6_rem = 17'(p5_r0_r - 18'(HUE_FULL));
    end else begin
      p6_rem = p5_r0_r[16:0];
    end
    if (p5_neg_r && (p6_rem != '0)) begin
      p6_h_nxt = HUE_FULL - p6_rem;
    end else begin
      p6_h_nxt = p6_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      p6_h_r   <= p6_h_nxt;
      p6_sat_r <= p5_sat_r;
      p6_bri_r <= p5_bri_r;
    end
  end

  // stage 7: sector decode, s*v and v*(255-s)
  sector_t     p7_sec_r, p7_sec_nxt;
  logic [13:0] p7_t_r, p7_t_nxt;
  logic [15:0] p7_sv_r, p7_sv_nxt;
  logic [15:0] p7_a_r, p7_a_nxt;
  logic [7:0]  p7_bri_r;
  logic [16:0] p7_tw;

  always_comb begin
    if (p6_h_r <= HUE_B1) begin
      p7_sec_nxt = SEC_RED_YEL;
      p7_tw      = p6_h_r;
    end else if (p6_h_r <= HUE_B2) begin
      p7_sec_nxt = SEC_YEL_GRN;
      p7_tw      = HUE_B2 - p6_h_r;
    end else if (p6_h_r <= HUE_B3) begin
      p7_sec_nxt = SEC_GRN_CYN;
      p7_tw      = p6_h_r - HUE_B2;
    end else if (p6_h_r <= HUE_B4) begin
      p7_sec_nxt = SEC_CYN_BLU;
      p7_tw      = HUE_B4 - p6_h_r;
    end else if (p6_h_r <= HUE_B5) begin
      p7_sec_nxt = SEC_BLU_MAG;
      p7_tw      = p6_h_r - HUE_B4;
    end else begin
      p7_sec_nxt = SEC_MAG_RED;
      p7_tw      = HUE_FULL - p6_h_r;
    end
    p7_t_nxt  = p7_tw[13:0];
    p7_sv_nxt = 16'(p6_sat_r) * 16'(p6_bri_r);
    p7_a_nxt  = 16'(p6_bri_r) * 16'(8'(8'd255 - p6_sat_r));
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      p7_sec_r <= p7_sec_nxt;
      p7_t_r   <= p7_t_nxt;
      p7_sv_r  <= p7_sv_nxt;
      p7_a_r   <= p7_a_nxt;
      p7_bri_r <= p6_bri_r;
    end
  end

  // stage 8: channel numerators, rounding offset included
  logic [29:0] p8_base;
  logic [29:0] p8_nlo_r, p8_nlo_nxt;
  logic [29:0] p8_nmid_r, p8_nmid_nxt;
  sector_t     p8_sec_r;
  logic [7:0]  p8_bri_r;

  always_comb begin
    p8_base     = 30'(p7_a_r) * 30'(HUE_SECT) + CH_HALF;
    p8_nlo_nxt  = p8_base;
    p8_nmid_nxt = p8_base + 30'(p7_sv_r) * 30'(p7_t_r);
  end

  always_ff @(posedge clk) begin
    if (load[7]) begin
      p8_nlo_r  <= p8_nlo_nxt;
      p8_nmid_r <= p8_nmid_nxt;
      p8_sec_r  <= p7_sec_r;
      p8_bri_r  <= p7_bri_r;
    end
  end

  // stage 9: reciprocal multiply, estimate low by at most one
  logic [60:0] p9_plo, p9_pmid;
  logic [7:0]  p9_qlo_r, p9_qlo_nxt, p9_qmid_r, p9_qmid_nxt;
  logic [29:0] p9_nlo_r, p9_nmid_r;
  sector_t     p9_sec_r;
  logic [7:0]  p9_bri_r;

  always_comb begin
    p9_plo      = 61'(p8_nlo_r) * 61'(CH_RECIP);
    p9_pmid     = 61'(p8_nmid_r) * 61'(CH_RECIP);
    p9_qlo_nxt  = p9_plo[59:52];
    p9_qmid_nxt = p9_pmid[59:52];
  end

  always_ff @(posedge clk) begin
    if (load[8]) begin
      p9_qlo_r  <= p9_qlo_nxt;
      p9_qmid_r <= p9_qmid_nxt;
      p9_nlo_r  <= p8_nlo_r;
      p9_nmid_r <= p8_nmid_r;
      p9_sec_r  <= p8_sec_r;
      p9_bri_r  <= p8_bri_r;
    end
  end

  // stage 10: correction and channel routing
  logic [29:0] p10_remlo, p10_remmid;
  logic [7:0]  p10_lo, p10_mid, p10_hi;
  logic [7:0]  p10_red_r, p10_red_nxt;
  logic [7:0]  p10_green_r, p10_green_nxt;
  logic [7:0]  p10_blue_r, p10_blue_nxt;

  always_comb begin
    p10_remlo  = p9_nlo_r - 30'(p9_qlo_r) * CH_DEN;
    p10_remmid = p9_nmid_r - 30'(p9_qmid_r) * CH_DEN;
    p10_lo     = (p10_remlo >= CH_DEN) ? p9_qlo_r + 8'd1 : p9_qlo_r;
    p10_mid    = (p10_remmid >= CH_DEN) ? p9_qmid_r + 8'd1 : p9_qmid_r;
    p10_hi     = p9_bri_r;
    unique case (p9_sec_r)
      SEC_RED_YEL: begin
        p10_red_nxt = p10_hi; p10_green_nxt = p10_mid; p10_blue_nxt = p10_lo;
      end
      SEC_YEL_GRN: begin
        p10_red_nxt = p10_mid; p10_green_nxt = p10_hi; p10_blue_nxt = p10_lo;
      end
      SEC_GRN_CYN: begin
        p10_red_nxt = p10_lo; p10_green_nxt = p10_hi; p10_blue_nxt = p10_mid;
      end
      SEC_CYN_BLU: begin
        p10_red_nxt = p10_lo; p10_green_nxt = p10_mid; p10_blue_nxt = p10_hi;
      end
      SEC_BLU_MAG: begin
        p10_red_nxt = p10_mid; p10_green_nxt = p10_lo; p10_blue_nxt = p10_hi;
      end
      default: begin
        p10_red_nxt = p10_hi; p10_green_nxt = p10_lo; p10_blue_nxt = p10_mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[9]) begin
      p10_red_r   <= p10_red_nxt;
      p10_green_r <= p10_green_nxt;
      p10_blue_r  <= p10_blue_nxt;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {p10_blue_r, p10_green_r, p10_red_r};

  `HTR_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_tready, &vld_r,
    "input blocked while pipeline has an empty stage")
  `HTR_ASSERT_NOW(a_wrap_rem_bound, clk, rst_n, vld_r[4], p5_r0_r < 18'd184320,
    "hue wrap quotient estimate off by more than one")
  `HTR_ASSERT_NOW(a_hue_range, clk, rst_n, vld_r[5], p6_h_r < HUE_FULL,
    "wrapped hue out of range")
  `HTR_ASSERT_NEXT(a_stage_advance, clk, rst_n, vld_r[4] && load[5], vld_r[5],
    "pixel lost between remainder and wrap stages")

endmodule

>>> dv/tb_hsv_to_rgb_converter.sv
// Testbench for hsv_to_rgb_converter: directed and random pixels, random idling and
// back-pressure, results checked against a bit-exact fixed-point HSV to RGB model.
// Depends on htr_pkg (sector codes) and the converter RTL.
module tb_hsv_to_rgb_converter;
  import htr_pkg::*;

  localparam int HUE_FRAC_BITS = 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 60;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } rgb_t;

  class rgb_scoreboard;
    localparam longint unsigned DEG_PER_RAD_Q16 = 64'd3754938;
    localparam longint unsigned SECTOR = 64'd15360;
    localparam longint unsigned FULL   = 64'd92160;
    localparam longint unsigned DEN    = 64'd255 * 64'd15360;

    rgb_t expected_q[$];
    int   errors;

    // min + span * t / 60, rounded half up
    function bit [7:0] ramp(longint unsigned v, longint unsigned s, longint unsigned t);
      longint unsigned num;
      if (t > SECTOR) t = SECTOR;
      num = v * DEN - s * v * SECTOR + s * v * t;
      return 8'((num + DEN / 2) / DEN);
    endfunction

    function rgb_t expected_rgb(bit [15:0] hue, bit [7:0] sat, bit [7:0] bright);
      longint unsigned mag, deg, rem, h, v, s;
      bit [7:0] lo, hi;
      sector_t sect;
      rgb_t px;
      v = bright;
      s = sat;
      mag = hue[15] ? 64'd65536 - hue : hue;
      deg = (mag * DEG_PER_RAD_Q16 + (64'd1 << (HUE_FRAC_BITS + 7))) >> (HUE_FRAC_BITS + 8);
      rem = deg % FULL;
      h = (hue[15] && rem != 0) ? FULL - rem : rem;
      lo = ramp(v, s, 0);
      hi = ramp(v, s, SECTOR);
      if (h <= SECTOR)          sect = SEC_RED_YEL;
      else if (h <= 2 * SECTOR) sect = SEC_YEL_GRN;
      else if (h <= 3 * SECTOR) sect = SEC_GRN_CYN;
      else if (h <= 4 * SECTOR) sect = SEC_CYN_BLU;
      else if (h <= 5 * SECTOR) sect = SEC_BLU_MAG;
      else                      sect = SEC_MAG_RED;
      case (sect)
        SEC_RED_YEL: begin
          px.red = hi; px.green = ramp(v, s, h); px.blue = lo;
        end
        SEC_YEL_GRN: begin
          px.red = ramp(v, s, 2 * SECTOR - h); px.green = hi; px.blue = lo;
        end
        SEC_GRN_CYN: begin
          px.red = lo; px.green = hi; px.blue = ramp(v, s, h - 2 * SECTOR);
        end
        SEC_CYN_BLU: begin
          px.red = lo; px.green = ramp(v, s, 4 * SECTOR - h); px.blue = hi;
        end
        SEC_BLU_MAG: begin
          px.red = ramp(v, s, h - 4 * SECTOR); px.green = lo; px.blue = hi;
        end
        default: begin
          px.red = hi; px.green = lo; px.blue = ramp(v, s, 6 * SECTOR - h);
        end
      endcase
      return px;
    endfunction

    function void note_pixel(bit [15:0] hue, bit [7:0] sat, bit [7:0] bright);
      expected_q.push_back(expected_rgb(hue, sat, bright));
    endfunction

    function void check_pixel(logic [23:0] data);
      rgb_t exp_px;
      if (expected_q.size() == 0) begin
        $error("out_tdata: unexpected transfer, got %h", data);
        errors++;
        return;
      end
      exp_px = expected_q.pop_front();
      if (data[7:0] !== exp_px.red) begin
        $error("red: expected %0d, got %0d", exp_px.red, data[7:0]);
        errors++;
      end
      if (data[15:8] !== exp_px.green) begin
        $error("green: expected %0d, got %0d", exp_px.green, data[15:8]);
        errors++;
      end
      if (data[23:16] !== exp_px.blue) begin
        $error("blue: expected %0d, got %0d", exp_px.blue, data[23:16]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] hue_radians, [23:16] saturation, [31:24] brightness
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] red, [15:8] green, [23:16] blue

  rgb_scoreboard sb = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  hsv_to_rgb_converter #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result sink: random stall bursts, plus a long hold on request
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_pixel(bit [15:0] hue, bit [7:0] sat, bit [7:0] bright);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {bright, sat, hue};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(hue, sat, bright);
  endtask

  task automatic sender_gap(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
    end
  endtask

  // mostly random hue, some clustered around sector edges and 360-degree wraps
  function automatic bit [15:0] pick_hue();
    int k;
    if ($urandom_range(0, 5) == 0) begin
      k = int'($urandom_range(0, 14)) - 7;
      return 16'((k * 12868) / 3 + int'($urandom_range(0, 16)) - 8);
    end
    return 16'($urandom());
  endfunction

  function automatic bit [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic random_pixels(int n);
    repeat (n) begin
      if (idle_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 4));
      send_pixel(pick_hue(), pick_level(), pick_level());
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes, sector edges, full turns, negative wrap
    send_pixel(16'd0, 8'd255, 8'd255);
    send_pixel(16'd0, 8'd0, 8'd255);
    send_pixel(16'd0, 8'd255, 8'd0);
    send_pixel(16'd0, 8'd0, 8'd0);
    send_pixel(16'h7FFF, 8'd255, 8'd255);
    send_pixel(16'h8000, 8'd255, 8'd255);
    send_pixel(16'hFFFF, 8'd255, 8'd255);
    send_pixel(16'd1, 8'd255, 8'd255);
    send_pixel(16'd4289, 8'd255, 8'd255);
    send_pixel(16'd4290, 8'd255, 8'd255);
    send_pixel(16'd8579, 8'd200, 8'd255);
    send_pixel(16'd12868, 8'd255, 8'd128);
    send_pixel(16'd17157, 8'd255, 8'd255);
    send_pixel(16'd21447, 8'd128, 8'd200);
    send_pixel(16'd25736, 8'd255, 8'd255);
    send_pixel(16'd25735, 8'd255, 8'd255);
    send_pixel(-16'sd25736, 8'd255, 8'd255);
    send_pixel(-16'sd4289, 8'd255, 8'd255);
    send_pixel(-16'sd12868, 8'd100, 8'd50);
    send_pixel(16'd2000, 8'd1, 8'd1);
    send_pixel(16'd6000, 8'd255, 8'd255);
    send_pixel(16'd10000, 8'd128, 8'd128);
    send_pixel(16'd15000, 8'd17, 8'd240);
    send_pixel(16'd19000, 8'd255, 8'd255);
    send_pixel(16'd23000, 8'd255, 8'd77);

    random_pixels(700);

    // sink holds off while the source keeps pushing: pipe fills, in_tready drops
    idle_on = 1'b0;
    hold_req = 1'b1;
    random_pixels(40);
    idle_on = 1'b1;

    sender_gap(1);
    wait_drained();

    random_pixels(650);

    idle_on = 1'b0;
    random_pixels(200);
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
